// File: sv/mfm_pkg.sv
// shared types and constants for the masked id first-match table
`timescale 1ns / 1ps

package mfm_pkg;

	// item kinds
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// register select, taken from paddr bit 2
	localparam logic REG_SEL_ENTRY_COUNT = 1'b0;
	localparam int   REG_ENTRY_COUNT_W   = 7;

	// match-enable flag positions
	localparam int FLG_VENDOR    = 0;
	localparam int FLG_PRODUCT   = 1;
	localparam int FLG_REL_LO    = 2;
	localparam int FLG_REL_HI    = 3;
	localparam int FLG_DEV_CLASS = 4;
	localparam int FLG_DEV_SUB   = 5;
	localparam int FLG_DEV_PROTO = 6;
	localparam int FLG_ITF_CLASS = 7;
	localparam int FLG_ITF_SUB   = 8;
	localparam int FLG_ITF_PROTO = 9;

	typedef struct packed {
		logic [9:0]  flags;
		logic [15:0] vendor;
		logic [15:0] product;
		logic [15:0] rel_lo;
		logic [15:0] rel_hi;
		logic [23:0] dev;
		logic [23:0] itf;
		logic [31:0] driver;
	} entry_t;

	typedef struct packed {
		logic [15:0] vendor;
		logic [15:0] product;
		logic [15:0] release_no;
		logic [23:0] dev;
		logic [23:0] itf;
	} key_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

endpackage

// File: sv/masked_id_first_match_table_core.sv
// top level: first-match id table with sequential entry scan
// write item: stored at the accept edge, where its result strobe (not found) is also registered
// lookup item: one entry read per cycle from the entry memory, registered, then compared;
//   the result strobe is registered at the first hit or the last entry, as busy falls
// a lookup with an entry count of zero answers without a scan; the receiver cannot stall results
// arst_n clears entry_count and control; the entry memory is not cleared
`timescale 1ns / 1ps

module masked_id_first_match_table_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [5:0]  entry_index,
	input  logic [9:0]  match_flags,
	input  logic [15:0] vendor_id,
	input  logic [15:0] product_id,
	input  logic [15:0] release_lo,
	input  logic [15:0] release_hi,
	input  logic [23:0] device_triple,
	input  logic [23:0] interface_triple,
	input  logic [31:0] driver_word,
	output logic        done,
	output logic        found,
	output logic [5:0]  match_index,
	output logic [31:0] match_driver_word
);
	import mfm_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > REG_ENTRY_COUNT_W) ? CW : REG_ENTRY_COUNT_W;

	state_t                       state_q;
	logic [REG_ENTRY_COUNT_W-1:0] entry_count_q;
	logic                         issue_q;
	logic [AW-1:0]                rd_idx_q;
	logic [CW-1:0]                limit_q;
	key_t                         key_q;
	logic                         vld_s1;
	logic                         last_s1;
	logic [AW-1:0]                idx_s1;
	logic                         done_q;
	logic                         found_q;
	logic [5:0]                   idx_q;
	logic [31:0]                  drv_q;

	logic          accept;
	logic          cfg_wr;
	logic          wr_en;
	entry_t        wr_entry;
	key_t          key_in;
	logic [LW-1:0] lim_wide;
	logic [CW-1:0] limit;
	logic          issue_last;
	logic          rd_en;
	entry_t        rd_entry;
	logic          hit;

	assign accept = start && !busy;
	assign busy   = state_q != ST_IDLE;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	assign prdata = (paddr[2] == REG_SEL_ENTRY_COUNT) ?
		{{(32-REG_ENTRY_COUNT_W){1'b0}}, entry_count_q} : 32'd0;

	// slots at or above the table depth are dropped
	assign wr_en = accept && (kind == KIND_WRITE) &&
		(LW'(entry_index) < LW'(TABLE_DEPTH));

	assign wr_entry = '{
		flags:   match_flags,
		vendor:  vendor_id,
		product: product_id,
		rel_lo:  release_lo,
		rel_hi:  release_hi,
		dev:     device_triple,
		itf:     interface_triple,
		driver:  driver_word
	};

	assign key_in = '{
		vendor:     vendor_id,
		product:    product_id,
		release_no: release_lo,
		dev:        device_triple,
		itf:        interface_triple
	};

	// count above the table depth is clamped
	assign lim_wide = (LW'(entry_count_q) > LW'(TABLE_DEPTH)) ?
		LW'(TABLE_DEPTH) : LW'(entry_count_q);
	assign limit = CW'(lim_wide);

	assign issue_last = CW'(rd_idx_q) == CW'(limit_q - CW'(1));
	assign rd_en      = (state_q == ST_SCAN) && issue_q;

	// busy blocks writes during a scan, so reads never race a write
	mfm_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(entry_index)),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (rd_entry)
	);

	mfm_match u_match (
		.entry (rd_entry),
		.key   (key_q),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			issue_q       <= 1'b0;
			rd_idx_q      <= '0;
			vld_s1        <= 1'b0;
			done_q        <= 1'b0;
			found_q       <= 1'b0;
			idx_q         <= '0;
			drv_q         <= '0;
		end else begin
			done_q  <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
			drv_q   <= '0;
			vld_s1  <= 1'b0;

			if (cfg_wr && (paddr[2] == REG_SEL_ENTRY_COUNT)) begin
				entry_count_q <= pwdata[REG_ENTRY_COUNT_W-1:0];
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_WRITE) begin
							done_q <= 1'b1;
						end else if (limit == '0) begin
							done_q <= 1'b1;
						end else begin
							key_q    <= key_in;
							limit_q  <= limit;
							rd_idx_q <= '0;
							issue_q  <= 1'b1;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						vld_s1  <= 1'b1;
						idx_s1  <= rd_idx_q;
						last_s1 <= issue_last;
						if (issue_last) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + AW'(1);
						end
					end
					// a hit cancels the read already in flight
					if (vld_s1) begin
						if (hit) begin
							done_q  <= 1'b1;
							found_q <= 1'b1;
							idx_q   <= 6'(idx_s1);
							drv_q   <= rd_entry.driver;
							issue_q <= 1'b0;
							vld_s1  <= 1'b0;
							state_q <= ST_IDLE;
						end else if (last_s1) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					issue_q <= 1'b0;
				end
			endcase
		end
	end

	assign done              = done_q;
	assign found             = found_q;
	assign match_index       = idx_q;
	assign match_driver_word = drv_q;

endmodule

// File: sv/mfm_entry_ram.sv
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps

module mfm_entry_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  mfm_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output mfm_pkg::entry_t   rdata
);
	import mfm_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/mfm_match.sv
// compares one stored entry against a device identity under its flags
`timescale 1ns / 1ps

module mfm_match (
	input  mfm_pkg::entry_t entry,
	input  mfm_pkg::key_t   key,
	output logic            hit
);
	import mfm_pkg::*;

	logic [9:0] ok;

	always_comb begin
		ok[FLG_VENDOR]    = entry.vendor == key.vendor;
		ok[FLG_PRODUCT]   = entry.product == key.product;
		ok[FLG_REL_LO]    = entry.rel_lo <= key.release_no;
		ok[FLG_REL_HI]    = entry.rel_hi >= key.release_no;
		ok[FLG_DEV_CLASS] = entry.dev[23:16] == key.dev[23:16];
		ok[FLG_DEV_SUB]   = entry.dev[15:8] == key.dev[15:8];
		ok[FLG_DEV_PROTO] = entry.dev[7:0] == key.dev[7:0];
		ok[FLG_ITF_CLASS] = entry.itf[23:16] == key.itf[23:16];
		ok[FLG_ITF_SUB]   = entry.itf[15:8] == key.itf[15:8];
		ok[FLG_ITF_PROTO] = entry.itf[7:0] == key.itf[7:0];
	end

	// a disabled check always passes
	assign hit = &(ok | ~entry.flags);

endmodule

// File: sv/mfm_checker.sv
// port-level checks for the first-match table, bound to the top level
`timescale 1ns / 1ps

module mfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        kind,
	input logic        done,
	input logic        found,
	input logic [5:0]  match_index,
	input logic [31:0] match_driver_word
);
	import mfm_pkg::*;

	// the result strobe only comes once the scan has ended
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_WRITE) |=> (done && !found && !busy))
		else $error("write item gave no plain result");

	a_lookup_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_LOOKUP) |=> (busy || done))
		else $error("lookup item neither scanned nor answered");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!found |-> (match_index == 6'd0 && match_driver_word == 32'd0))
		else $error("miss result carries non-zero fields");

	a_found_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		found |-> done)
		else $error("found without result strobe");

endmodule

bind masked_id_first_match_table_core mfm_checker u_mfm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.start             (start),
	.busy              (busy),
	.kind              (kind),
	.done              (done),
	.found             (found),
	.match_index       (match_index),
	.match_driver_word (match_driver_word)
);

// File: tb/sv/masked_id_first_match_table_core_test.sv
// self-checking testbench for the masked id first-match table core
`timescale 1ns / 1ps

module masked_id_first_match_table_core_test;
	import mfm_pkg::*;

	localparam int DEPTH = 64;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 70;
	localparam int PHASE_ITEMS = 150;
	localparam logic [2:0] ADDR_ENTRY_COUNT = {REG_SEL_ENTRY_COUNT, 2'b00};

	typedef struct packed {
		logic        kind;
		logic [5:0]  idx;
		logic [9:0]  flags;
		logic [15:0] vendor;
		logic [15:0] product;
		logic [15:0] rel_lo;
		logic [15:0] rel_hi;
		logic [23:0] dev;
		logic [23:0] itf;
		logic [31:0] drv;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic [5:0]  idx;
		logic [31:0] drv;
	} answer_t;

	typedef struct packed {
		logic       set_count;
		logic [6:0] count;
		cmd_t       cmd;
		logic       typed;
		answer_t    exp;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        kind;
	logic [5:0]  entry_index;
	logic [9:0]  match_flags;
	logic [15:0] vendor_id, product_id, release_lo, release_hi;
	logic [23:0] device_triple, interface_triple;
	logic [31:0] driver_word;
	logic        done;
	logic        found;
	logic [5:0]  match_index;
	logic [31:0] match_driver_word;

	masked_id_first_match_table_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.kind(kind), .entry_index(entry_index), .match_flags(match_flags),
		.vendor_id(vendor_id), .product_id(product_id),
		.release_lo(release_lo), .release_hi(release_hi),
		.device_triple(device_triple), .interface_triple(interface_triple),
		.driver_word(driver_word),
		.done(done), .found(found), .match_index(match_index),
		.match_driver_word(match_driver_word)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	entry_t     id_table [DEPTH];
	logic [DEPTH-1:0] slot_filled = '0;
	logic [6:0] scan_count = '0;

	answer_t pending_answers [$];
	int errors = 0;
	int idle_pct = 23;
	int stall_cycles = 0;
	int n_writes = 0, n_lookups = 0, n_hits = 0, deepest_hit = 0, n_settings = 0;

	logic [6:0] phase_counts [9] = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd8, 7'd65, 7'd3, 7'd64,
		7'd100};

	row_t dir_rows [23] = '{
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'h3f, 10'h3ff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			24'hffffff, 24'hffffff, 32'hffffffff}, 1'b1, '0},
		'{1'b0, 7'd0, '{KIND_WRITE, 6'd0, 10'h3ff, 16'hffff, 16'hffff, 16'h0000, 16'hffff,
			24'hffffff, 24'hffffff, 32'hffffffff}, 1'b1, '0},
		'{1'b0, 7'd0, '{KIND_WRITE, 6'd63, 10'h000, 16'h0, 16'h0, 16'h0, 16'h0,
			24'h0, 24'h0, 32'hcafe0063}, 1'b1, '0},
		'{1'b0, 7'd0, '{KIND_WRITE, 6'd1, 10'h00c, 16'h5a5a, 16'ha5a5, 16'h0100, 16'h0200,
			24'h5a5a5a, 24'ha5a5a5, 32'h11111111}, 1'b1, '0},
		'{1'b0, 7'd0, '{KIND_WRITE, 6'd2, 10'h3f0, 16'h0, 16'h0, 16'h0, 16'h0,
			24'h030201, 24'h060504, 32'h22222222}, 1'b1, '0},
		'{1'b0, 7'd0, '{KIND_WRITE, 6'd3, 10'h003, 16'h1234, 16'h5678, 16'h0, 16'h0,
			24'h0, 24'h0, 32'h33333333}, 1'b1, '0},
		'{1'b0, 7'd0, '{KIND_WRITE, 6'd4, 10'h000, 16'h0, 16'h0, 16'h0, 16'h0,
			24'h0, 24'h0, 32'h44444444}, 1'b1, '0},
		'{1'b1, 7'd1, '0, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'hffff, 16'hffff, 16'h8000, 16'h0,
			24'hffffff, 24'hffffff, 32'd0}, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h0, 16'h0, 16'h0, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		'{1'b1, 7'd5, '0, 1'b0, '0},
		// release just under, at and just over the bounds of slot 1
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h0, 16'h0, 16'h00ff, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h0, 16'h0, 16'h0100, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h0, 16'h0, 16'h0200, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h0, 16'h0, 16'h0201, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		// class triples, then one protocol byte off
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h0, 16'h0, 16'h0, 16'h0,
			24'h030201, 24'h060504, 32'd0}, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h0, 16'h0, 16'h0, 16'h0,
			24'h030201, 24'h060505, 32'd0}, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h1234, 16'h5678, 16'h0, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'h1234, 16'h5679, 16'h0, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		// count beyond the table depth
		'{1'b1, 7'd127, '0, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'hbeef, 16'h0, 16'h0150, 16'h0,
			24'h0, 24'h0, 32'd0}, 1'b0, '0},
		'{1'b1, 7'd64, '0, 1'b0, '0},
		'{1'b0, 7'd0, '{KIND_LOOKUP, 6'd0, 10'd0, 16'hffff, 16'hffff, 16'hffff, 16'h0,
			24'hffffff, 24'hffffff, 32'd0}, 1'b0, '0}
	};

	function automatic bit entry_hits(input entry_t e, input key_t k);
		if (e.flags[FLG_VENDOR] && e.vendor != k.vendor) return 1'b0;
		if (e.flags[FLG_PRODUCT] && e.product != k.product) return 1'b0;
		if (e.flags[FLG_REL_LO] && e.rel_lo > k.release_no) return 1'b0;
		if (e.flags[FLG_REL_HI] && e.rel_hi < k.release_no) return 1'b0;
		if (e.flags[FLG_DEV_CLASS] && e.dev[23:16] != k.dev[23:16]) return 1'b0;
		if (e.flags[FLG_DEV_SUB] && e.dev[15:8] != k.dev[15:8]) return 1'b0;
		if (e.flags[FLG_DEV_PROTO] && e.dev[7:0] != k.dev[7:0]) return 1'b0;
		if (e.flags[FLG_ITF_CLASS] && e.itf[23:16] != k.itf[23:16]) return 1'b0;
		if (e.flags[FLG_ITF_SUB] && e.itf[15:8] != k.itf[15:8]) return 1'b0;
		if (e.flags[FLG_ITF_PROTO] && e.itf[7:0] != k.itf[7:0]) return 1'b0;
		return 1'b1;
	endfunction

	// first matching slot or -1; gap is the first never-written slot the scan would touch
	function automatic int search_table(input key_t k, output int gap);
		int lim;
		gap = -1;
		lim = (int'(scan_count) > DEPTH) ? DEPTH : int'(scan_count);
		for (int i = 0; i < lim; i++) begin
			if (!slot_filled[i]) begin
				gap = i;
				return -1;
			end
			if (entry_hits(id_table[i], k)) return i;
		end
		return -1;
	endfunction

	function automatic key_t key_of(input cmd_t c);
		return '{c.vendor, c.product, c.rel_lo, c.dev, c.itf};
	endfunction

	function automatic answer_t predict_answer(input cmd_t c);
		answer_t a;
		int hit, gap;
		a = '0;
		if (c.kind == KIND_WRITE) begin
			id_table[c.idx] = '{c.flags, c.vendor, c.product, c.rel_lo, c.rel_hi,
				c.dev, c.itf, c.drv};
			slot_filled[c.idx] = 1'b1;
			n_writes++;
		end else begin
			hit = search_table(key_of(c), gap);
			n_lookups++;
			if (hit >= 0) begin
				a.found = 1'b1;
				a.idx = 6'(hit);
				a.drv = id_table[hit].driver;
				n_hits++;
				if (hit > deepest_hit) deepest_hit = hit;
			end
		end
		return a;
	endfunction

	function automatic cmd_t random_entry(input logic [5:0] slot);
		cmd_t c;
		int sel;
		sel = $urandom_range(0, 15);
		c.kind = KIND_WRITE;
		c.idx = slot;
		c.flags = (sel == 0) ? 10'h000 : (sel == 1) ? 10'h3ff : 10'($urandom);
		c.vendor = 16'($urandom);
		c.product = 16'($urandom);
		c.rel_lo = 16'($urandom);
		c.rel_hi = 16'($urandom);
		// mostly sane release windows, some inverted
		if (sel % 4 != 3 && c.rel_lo > c.rel_hi) {c.rel_lo, c.rel_hi} = {c.rel_hi, c.rel_lo};
		c.dev = 24'($urandom);
		c.itf = 24'($urandom);
		c.drv = $urandom;
		return c;
	endfunction

	// identity mostly copied from a live entry, sometimes nudged off it
	function automatic cmd_t random_lookup();
		cmd_t c;
		entry_t e;
		int lim, j, b;
		c = random_entry(6'($urandom));
		c.kind = KIND_LOOKUP;
		lim = (int'(scan_count) > DEPTH) ? DEPTH : int'(scan_count);
		if (lim > 0 && $urandom_range(0, 9) < 8) begin
			j = $urandom_range(0, lim - 1);
			if (slot_filled[j]) begin
				e = id_table[j];
				c.vendor = e.vendor;
				c.product = e.product;
				c.dev = e.dev;
				c.itf = e.itf;
				c.rel_lo = (e.rel_lo <= e.rel_hi) ?
					16'($urandom_range(int'(e.rel_hi), int'(e.rel_lo))) : e.rel_lo;
				b = $urandom_range(0, 23);
				case ($urandom_range(0, 11))
					0: c.vendor ^= 16'(1) << b[3:0];
					1: c.product ^= 16'(1) << b[3:0];
					2: c.dev ^= 24'(1) << b;
					3: c.itf ^= 24'(1) << b;
					4: c.rel_lo = 16'(e.rel_lo - 16'd1);
					5: c.rel_lo = 16'(e.rel_hi + 16'd1);
					6: c.rel_lo = e.rel_lo;
					7: c.rel_lo = e.rel_hi;
					default: ;
				endcase
			end
		end
		return c;
	endfunction

	task automatic wait_drained();
		start = 1'b0;
		do @(negedge clk); while (pending_answers.size() != 0 || busy);
	endtask

	task automatic set_entry_count(input logic [6:0] n);
		wait_drained();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_ENTRY_COUNT;
		pwdata = 32'(n);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		scan_count = n;
		n_settings++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// called at a falling edge; returns at the falling edge after the item is taken
	task automatic issue(input cmd_t c, input bit typed, input answer_t typed_ans);
		answer_t a;
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		kind = c.kind;
		entry_index = c.idx;
		match_flags = c.flags;
		vendor_id = c.vendor;
		product_id = c.product;
		release_lo = c.rel_lo;
		release_hi = c.rel_hi;
		device_triple = c.dev;
		interface_triple = c.itf;
		driver_word = c.drv;
		start = 1'b1;
		do @(posedge clk); while (busy);
		a = predict_answer(c);
		pending_answers.push_back(typed ? typed_ans : a);
		@(negedge clk);
	endtask

	task automatic report(input string what, input longint want, input longint got);
		errors++;
		$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		answer_t want;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got found=%0b index=%0d drv=%h",
					$time, found, match_index, match_driver_word);
			end else begin
				want = pending_answers.pop_front();
				if (found !== want.found) report("found", want.found, found);
				if (match_index !== want.idx) report("match_index", want.idx, match_index);
				if (match_driver_word !== want.drv)
					report("match_driver_word", want.drv, match_driver_word);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		cmd_t c;
		int gap, hit;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		kind = KIND_WRITE;
		entry_index = '0;
		match_flags = '0;
		vendor_id = '0;
		product_id = '0;
		release_lo = '0;
		release_hi = '0;
		device_triple = '0;
		interface_triple = '0;
		driver_word = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].set_count) begin
				set_entry_count(dir_rows[r].count);
			end else begin
				issue(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].exp);
			end
		end

		for (int ph = 0; ph < 9; ph++) begin
			idle_pct = (ph < 3) ? 23 : (ph < 6) ? 62 : 0;
			set_entry_count((ph == 8) ? 7'($urandom_range(2, 127)) : phase_counts[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 49) == 0) wait_drained();
				if ($urandom_range(0, 99) < 55) begin
					c = random_lookup();
					// never let a scan run into a slot that was never written
					hit = search_table(key_of(c), gap);
					if (gap >= 0) c = random_entry(6'(gap));
				end else begin
					c = random_entry(6'($urandom));
				end
				issue(c, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d writes and %0d lookups over %0d entry-count settings",
			n_writes, n_lookups, n_settings);
		$display("%0d lookups hit, deepest first match at slot %0d", n_hits, deepest_hit);
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: masked_id_first_match_table_core.f
sv/mfm_pkg.sv
sv/mfm_entry_ram.sv
sv/mfm_match.sv
sv/masked_id_first_match_table_core.sv
sv/mfm_checker.sv
tb/sv/masked_id_first_match_table_core_test.sv
